@@ src/btt_pkg.sv @@
// ----------------------------------------------------------------------------
// Bucketed transposition table package
// Shared types and constants for the table, its update logic and its ports.
// ----------------------------------------------------------------------------
package btt_pkg;

    localparam int BUCKETS     = 4096;
    localparam int WAYS        = 4;
    localparam int BUCKET_W    = $clog2(BUCKETS);
    localparam int WAY_W       = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int DEPTH_MARGIN = 3;
    localparam int TAG_SHIFT   = 32;
    localparam logic [14:0] FILL_MAX = 15'h7FFF;
    localparam logic [14:0] MATE_THR_RESET = 15'd31000;

    typedef enum logic [1:0] {
        FUNC_PROBE = 2'd0,
        FUNC_STORE = 2'd1,
        FUNC_CLEAR = 2'd2,
        FUNC_NONE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        BOUND_EXACT = 2'd0,
        BOUND_LOWER = 2'd1,
        BOUND_UPPER = 2'd2,
        BOUND_BAD   = 2'd3
    } bound_code_t;

    localparam logic REG_AGE = 1'b0;
    localparam logic REG_MATE = 1'b1;

    typedef struct packed {
        logic [1:0]         func;
        logic [63:0]        key;
        logic [6:0]         depth;
        logic signed [15:0] score;
        logic signed [15:0] static_eval;
        logic [1:0]         bound;
        logic [15:0]        move;
        logic [6:0]         ply;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
        logic               main_thread;
    } in_t;

    typedef struct packed {
        logic               hit;
        logic               cutoff;
        logic [15:0]        found_move;
        logic signed [15:0] found_score;
        logic signed [15:0] found_eval;
        logic [1:0]         found_bound;
        logic [6:0]         found_depth;
        logic [14:0]        fill_count;
    } out_t;

    // One way of a bucket: tag plus the 63-bit entry.
    typedef struct packed {
        logic [31:0]        tag;
        logic [5:0]         age;
        logic [1:0]         bound;
        logic [6:0]         depth;
        logic signed [15:0] eval;
        logic signed [15:0] score;
        logic [15:0]        move;
    } way_t;

    typedef way_t [WAYS-1:0] row_t;

    typedef struct packed {
        logic        wr_en;
        row_t        row;
        logic [14:0] fill;
        logic        clear;
        out_t        res;
    } upd_t;

endpackage

@@ src/btt_update.sv @@
// ----------------------------------------------------------------------------
// Bucket update logic
// Decides a probe, store or clear over one bucket read from the table.
// ----------------------------------------------------------------------------
module btt_update
    import btt_pkg::*;
(
    input  in_t         item,
    input  row_t        row,
    input  logic [5:0]  current_age,
    input  logic [14:0] mate_threshold,
    input  logic [14:0] fill,
    output upd_t        upd
);

    logic [31:0]        tag;
    logic               done;
    logic               skip;
    logic               found;
    logic [WAY_W-1:0]   sel;
    logic [WAY_W-1:0]   age_sel;
    logic [WAY_W-1:0]   dep_sel;
    logic               age_ok;
    logic               dep_ok;
    logic [5:0]         best_age;
    logic [6:0]         best_dep;
    logic [15:0]        mv;
    logic [14:0]        fill_new;
    logic signed [16:0] s_adj;
    logic signed [16:0] thr;
    logic signed [15:0] s_st;
    logic               p_hit;
    way_t               p_way;
    logic               cut;
    way_t               nw;

    assign tag = item.key[TAG_SHIFT +: 32];
    assign thr = {2'b00, mate_threshold};

    // Probe: first way whose tag matches.
    always_comb
    begin
        p_hit = 1'b0;
        p_way = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (row[i].tag == tag)
            begin
                p_hit = 1'b1;
                p_way = row[i];
            end
        end
        s_adj = 17'(p_way.score);
        if (s_adj >= thr)
            s_adj = s_adj - 17'(item.ply);
        else if (s_adj <= -thr)
            s_adj = s_adj + 17'(item.ply);
        unique case (bound_code_t'(p_way.bound))
            BOUND_EXACT: cut = 1'b1;
            BOUND_LOWER: cut = (s_adj >= 17'(item.beta));
            BOUND_UPPER: cut = (s_adj <= 17'(item.alpha));
            default:     cut = 1'b0;
        endcase
    end

    // Store: first way that matches or is empty, else replacement by age and depth.
    always_comb
    begin
        done     = 1'b0;
        skip     = 1'b0;
        found    = 1'b0;
        sel      = WAY_W'(WAYS - 1);
        age_sel  = '0;
        dep_sel  = '0;
        age_ok   = 1'b0;
        dep_ok   = 1'b0;
        best_age = current_age;
        best_dep = item.depth;
        mv       = item.move;
        fill_new = fill;
        for (int i = 0; i < WAYS; i++)
        begin
            if (!done)
            begin
                if (row[i].tag == tag)
                begin
                    done  = 1'b1;
                    found = 1'b1;
                    sel   = WAY_W'(i);
                    if (row[i].bound != 2'(BOUND_EXACT)
                        && 8'(item.depth) + 8'(DEPTH_MARGIN) < 8'(row[i].depth))
                        skip = 1'b1;
                    if (item.move == '0)
                        mv = row[i].move;
                end
                else if (row[i].tag == '0)
                begin
                    done  = 1'b1;
                    found = 1'b1;
                    sel   = WAY_W'(i);
                    if (item.main_thread && fill != FILL_MAX)
                        fill_new = fill + 15'd1;
                end
                else
                begin
                    if (row[i].age < best_age && row[i].depth < item.depth)
                    begin
                        best_age = row[i].age;
                        age_sel  = WAY_W'(i);
                        age_ok   = 1'b1;
                    end
                    if (row[i].age == current_age && row[i].depth < best_dep)
                    begin
                        best_dep = row[i].depth;
                        dep_sel  = WAY_W'(i);
                        dep_ok   = 1'b1;
                    end
                end
            end
        end
        if (!found)
        begin
            if (age_ok)
                sel = age_sel;
            else if (dep_ok)
                sel = dep_sel;
        end
    end

    // Mate adjustment on the way in, saturated to 16 bits.
    always_comb
    begin
        logic signed [16:0] t;
        t = 17'(item.score);
        if (t >= thr)
            t = t + 17'(item.ply);
        else if (t <= -thr)
            t = t - 17'(item.ply);
        if (t > 17'sd32767)
            s_st = 16'sh7FFF;
        else if (t < -17'sd32768)
            s_st = 16'sh8000;
        else
            s_st = t[15:0];
    end

    always_comb
    begin
        nw.tag   = tag;
        nw.age   = current_age;
        nw.bound = item.bound;
        nw.depth = item.depth;
        nw.eval  = item.static_eval;
        nw.score = s_st;
        nw.move  = mv;

        upd       = '0;
        upd.row   = row;
        upd.fill  = fill;
        unique case (func_t'(item.func))
            FUNC_PROBE:
            begin
                if (p_hit)
                begin
                    upd.res.hit         = 1'b1;
                    upd.res.cutoff      = cut;
                    upd.res.found_move  = p_way.move;
                    upd.res.found_score = s_adj[15:0];
                    upd.res.found_eval  = p_way.eval;
                    upd.res.found_bound = p_way.bound;
                    upd.res.found_depth = p_way.depth;
                end
            end
            FUNC_STORE:
            begin
                upd.fill = fill_new;
                if (!skip)
                begin
                    upd.wr_en    = 1'b1;
                    upd.row[sel] = nw;
                end
            end
            FUNC_CLEAR:
            begin
                upd.clear = 1'b1;
                upd.fill  = '0;
            end
            default:
            begin
                upd.fill = fill;
            end
        endcase
        upd.res.fill_count = upd.fill;
    end

endmodule

@@ src/bucketed_transposition_table.sv @@
// ----------------------------------------------------------------------------
// Bucketed transposition table
// Probe, store and clear of a bucketed hash table of search results.
// ----------------------------------------------------------------------------
// Usage: one transaction on the input channel (in_valid/in_stall/in_data)
// is a probe, a store or a clear; each gives exactly one transaction on the
// output channel (out_valid/out_stall/out_data). The bucket is key bits
// 11..0 and holds four ways in one row of a single-port table memory.
// For an item, the row is read at the accepting edge, and at
// the next edge the decision is written back and the result registered.
// Items are taken one at a time: a new item is not accepted until the
// last one has been written back to its row.
// A clear returns its result at once and then sweeps all 4096 rows, one a
// cycle; no item is accepted during the sweep. After reset the same
// sweep runs before the first item. Configuration writes over the APB port
// are taken at any time. A stalled result holds in the output register and
// blocks the next item until it is taken.
// ----------------------------------------------------------------------------
module bucketed_transposition_table
    import btt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_t         in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_t        out_data,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SWEEP
    } state_t;

    state_t              state_reg;
    logic [BUCKET_W-1:0] sweep_reg;
    logic [5:0]          age_reg;
    logic [14:0]         mate_reg;
    logic [14:0]         fill_reg;
    logic                out_valid_reg;
    out_t                out_data_reg;
    in_t                 item_reg;
    row_t                rd_reg;
    row_t                mem [BUCKETS];
    logic                accept;
    logic                cfg_wr;
    upd_t                upd;

    assign in_stall  = (state_reg != ST_IDLE) || (out_valid_reg && out_stall);
    assign accept    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_MATE) ? {17'd0, mate_reg} : {26'd0, age_reg};

    btt_update u_update (
        .item           (item_reg),
        .row            (rd_reg),
        .current_age    (age_reg),
        .mate_threshold (mate_reg),
        .fill           (fill_reg),
        .upd            (upd)
    );

    // Table memory: one row per bucket, registered read.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SWEEP)
            mem[sweep_reg] <= '0;
        else if (state_reg == ST_CALC && upd.wr_en)
            mem[item_reg.key[BUCKET_W-1:0]] <= upd.row;
        if (accept)
            rd_reg <= mem[in_data.key[BUCKET_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SWEEP;
            sweep_reg     <= '0;
            age_reg       <= '0;
            mate_reg      <= MATE_THR_RESET;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
            if (cfg_wr)
            begin
                if (paddr[2] == REG_AGE)
                    age_reg <= pwdata[5:0];
                else
                    mate_reg <= pwdata[14:0];
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                        state_reg <= ST_CALC;
                end
                ST_CALC:
                begin
                    out_valid_reg <= 1'b1;
                    out_data_reg  <= upd.res;
                    fill_reg      <= upd.fill;
                    if (upd.clear)
                    begin
                        age_reg   <= '0;
                        sweep_reg <= '0;
                        state_reg <= ST_SWEEP;
                    end
                    else
                        state_reg <= ST_IDLE;
                end
                ST_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == BUCKET_W'(BUCKETS - 1))
                        state_reg <= ST_IDLE;
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
